@@ src/mtf_pkg.sv @@
// ----------------------------------------------------------------------------
// mtf_pkg
// shared types, operation and status codes for the move-to-front list unit
// ----------------------------------------------------------------------------
package mtf_pkg;

    localparam int DEPTH_DEF       = 16;
    localparam int VALUE_WIDTH_DEF = 32;

    typedef enum logic [1:0] {
        FUNC_INSERT = 2'd0,
        FUNC_DELETE = 2'd1,
        FUNC_SEARCH = 2'd2,
        FUNC_NONE   = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    typedef struct packed {
        logic [1:0]         func;
        logic signed [31:0] value;
    } req_t;

    typedef struct packed {
        logic [1:0] status;
        logic [3:0] hit_position;
        logic [4:0] entry_count;
    } rsp_t;

endpackage

@@ src/mtf_ram.sv @@
// ----------------------------------------------------------------------------
// mtf_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module mtf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ src/move_to_front_list_unit.sv @@
// ----------------------------------------------------------------------------
// move_to_front_list_unit
// ordered list of up to DEPTH values kept in a ring buffer ram
// ----------------------------------------------------------------------------
// usage: drive req and raise start; the beat is taken when busy is low.
// every beat gives one result on rsp with done high for one cycle.
// insert and delete finish in the accept cycle; the result shows in the next
// cycle and busy stays low, so a new beat can follow at once.
// search walks the list from the front through the ram read port, with a
// read state and a compare state per entry looked at. a hit at position
// p > 0 then moves p entries back by one, each with a read and a write
// state, and a front state writes the value at the front. busy is high for
// the whole search.
// the front sits at a head pointer, so inserts cost no shifting.
// reset empties the list and clears head and count; ram contents are not
// cleared, only entries below the count are ever read.
// the receiver cannot stall: each result is valid for its one done cycle.
// ----------------------------------------------------------------------------
module move_to_front_list_unit #(
    parameter int DEPTH       = mtf_pkg::DEPTH_DEF,
    parameter int VALUE_WIDTH = mtf_pkg::VALUE_WIDTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  mtf_pkg::req_t req,
    output logic          done,
    output mtf_pkg::rsp_t rsp
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW:0]   DEPTH_W = (AW + 1)'(DEPTH);
    localparam logic [AW-1:0] LAST    = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_C  = CW'(DEPTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_CMP,
        S_MRD,
        S_MWR,
        S_FRONT
    } state_t;

    state_t                 state_reg, state_next;
    logic [AW-1:0]          head_reg, head_next;
    logic [CW-1:0]          count_reg, count_next;
    logic [AW-1:0]          k_reg, k_next;
    logic [AW-1:0]          hit_reg, hit_next;
    logic [VALUE_WIDTH-1:0] val_reg, val_next;
    logic                   done_reg, done_next;
    mtf_pkg::rsp_t          rsp_reg, rsp_next;

    logic                   ram_we;
    logic [AW-1:0]          ram_waddr;
    logic [AW-1:0]          ram_raddr;
    logic [VALUE_WIDTH-1:0] ram_wdata;
    logic [VALUE_WIDTH-1:0] ram_rdata;

    logic [63:0]            val_ext;
    logic [VALUE_WIDTH-1:0] in_val;
    logic [AW-1:0]          head_dec;
    logic [AW-1:0]          k_dec;

    function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a,
                                               input logic [AW-1:0] b);
        logic [AW:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= DEPTH_W)
        begin
            s = s - DEPTH_W;
        end
        return s[AW-1:0];
    endfunction

    function automatic mtf_pkg::rsp_t make_rsp(input mtf_pkg::status_t st,
                                               input logic [AW-1:0] hit,
                                               input logic [CW-1:0] cnt);
        mtf_pkg::rsp_t r;
        logic [AW+3:0] h;
        logic [CW+4:0] c;
        h = {4'b0, hit};
        c = {5'b0, cnt};
        r.status       = st;
        r.hit_position = h[3:0];
        r.entry_count  = c[4:0];
        return r;
    endfunction

    assign val_ext  = {{32{req.value[31]}}, req.value};
    assign in_val   = val_ext[VALUE_WIDTH-1:0];
    assign head_dec = (head_reg == '0) ? LAST : head_reg - 1'b1;
    assign k_dec    = k_reg - 1'b1;

    mtf_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        head_next  = head_reg;
        count_next = count_reg;
        k_next     = k_reg;
        hit_next   = hit_reg;
        val_next   = val_reg;
        done_next  = 1'b0;
        rsp_next   = rsp_reg;
        ram_we     = 1'b0;
        ram_waddr  = head_dec;
        ram_wdata  = in_val;
        ram_raddr  = wrap_add(head_reg, k_reg);

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    val_next  = in_val;
                    done_next = 1'b1;
                    case (req.func)
                        mtf_pkg::FUNC_INSERT:
                        begin
                            if (count_reg == FULL_C)
                            begin
                                rsp_next = make_rsp(mtf_pkg::ST_FULL, '0, count_reg);
                            end
                            else
                            begin
                                ram_we     = 1'b1;
                                head_next  = head_dec;
                                count_next = count_reg + 1'b1;
                                rsp_next   = make_rsp(mtf_pkg::ST_OK, '0,
                                                      count_reg + 1'b1);
                            end
                        end
                        mtf_pkg::FUNC_DELETE:
                        begin
                            if (count_reg == '0)
                            begin
                                rsp_next = make_rsp(mtf_pkg::ST_EMPTY, '0, count_reg);
                            end
                            else
                            begin
                                count_next = count_reg - 1'b1;
                                rsp_next   = make_rsp(mtf_pkg::ST_OK, '0,
                                                      count_reg - 1'b1);
                            end
                        end
                        mtf_pkg::FUNC_SEARCH:
                        begin
                            if (count_reg == '0)
                            begin
                                rsp_next = make_rsp(mtf_pkg::ST_NOT_FOUND, '0,
                                                    count_reg);
                            end
                            else
                            begin
                                done_next  = 1'b0;
                                k_next     = '0;
                                state_next = S_RD;
                            end
                        end
                        default:
                        begin
                            rsp_next = make_rsp(mtf_pkg::ST_OK, '0, count_reg);
                        end
                    endcase
                end
            end
            S_RD:
            begin
                state_next = S_CMP;
            end
            S_CMP:
            begin
                if (ram_rdata == val_reg)
                begin
                    hit_next = k_reg;
                    if (k_reg == '0)
                    begin
                        done_next  = 1'b1;
                        rsp_next   = make_rsp(mtf_pkg::ST_OK, '0, count_reg);
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_MRD;
                    end
                end
                else if (CW'(k_reg) + 1'b1 == count_reg)
                begin
                    done_next  = 1'b1;
                    rsp_next   = make_rsp(mtf_pkg::ST_NOT_FOUND, '0, count_reg);
                    state_next = S_IDLE;
                end
                else
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = S_RD;
                end
            end
            S_MRD:
            begin
                ram_raddr  = wrap_add(head_reg, k_dec);
                state_next = S_MWR;
            end
            S_MWR:
            begin
                ram_we     = 1'b1;
                ram_waddr  = wrap_add(head_reg, k_reg);
                ram_wdata  = ram_rdata;
                k_next     = k_dec;
                state_next = (k_dec == '0) ? S_FRONT : S_MRD;
            end
            S_FRONT:
            begin
                ram_we     = 1'b1;
                ram_waddr  = head_reg;
                ram_wdata  = val_reg;
                done_next  = 1'b1;
                rsp_next   = make_rsp(mtf_pkg::ST_OK, hit_reg, count_reg);
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            head_reg  <= '0;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg   <= k_next;
        hit_reg <= hit_next;
        val_reg <= val_next;
        rsp_reg <= rsp_next;
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule
